@@ src/lpcs_pkg.sv @@
// Package with the shared types and constants of the longest path or cycle search.
`default_nettype none
package lpcs_pkg;

    localparam int FIELD_W = 6;

    typedef struct packed {
        logic                opcode;
        logic [FIELD_W-1:0]  from_node;
        logic [FIELD_W-1:0]  to_node;
    } lpcs_in_t;

    typedef struct packed {
        logic                found_cycle;
        logic [FIELD_W-1:0]  run_length;
        logic [FIELD_W-1:0]  node_id;
        logic                last;
    } lpcs_out_t;

    localparam logic OP_EDGE  = 1'b0;
    localparam logic OP_START = 1'b1;

    localparam logic [1:0] MARK_WHITE = 2'd0;
    localparam logic [1:0] MARK_GRAY  = 2'd1;
    localparam logic [1:0] MARK_BLACK = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_ROOT,
        ST_SCAN,
        ST_FIND,
        ST_COPY,
        ST_PATH,
        ST_EMIT,
        ST_CLEAR
    } lpcs_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic add_edge;
        logic init;
        logic root_push;
        logic root_next;
        logic scan_step;
        logic find_step;
        logic copy_step;
        logic path_step;
        logic emit_load;
        logic emit_next;
        logic clear_step;
        logic clear_start;
    } lpcs_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic root_done;
        logic root_white;
        logic stack_empty;
        logic cycle_hit;
        logic find_done;
        logic copy_done;
        logic path_done;
        logic emit_empty;
        logic emit_final;
        logic clear_done;
    } lpcs_status_t;

endpackage
`default_nettype wire

@@ src/lpcs_datapath.sv @@
// Datapath of the search: adjacency memory, walk stack, node marks and result buffer.
`default_nettype none
module lpcs_datapath
    import lpcs_pkg::*;
#(
    parameter int NODES = 32
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic [5:0]    node_count,
    input  wire lpcs_in_t      in_beat,
    input  wire lpcs_cmd_t     cmd,
    output lpcs_status_t       status,
    output lpcs_out_t          out_beat
);

    localparam int IW = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int DW = $clog2(NODES + 2);

    logic [NODES-1:0]   adj_mem [NODES];
    logic [IW-1:0]      stack_mem [NODES];
    logic [NODES-1:0]   cursor_mem [NODES];
    logic [IW-1:0]      best_mem [NODES];
    logic [1:0]         mark_reg [NODES];
    logic [5:0]         slen_reg [NODES];
    logic [IW-1:0]      snext_reg [NODES];

    logic [DW-1:0]      depth_reg;
    logic [IW:0]        root_reg;
    logic [DW-1:0]      pos_reg;
    logic [5:0]         blen_reg;
    logic [DW-1:0]      bcnt_reg;
    logic [IW-1:0]      first_reg;
    logic [IW-1:0]      pv_reg;
    logic               cyc_reg;
    logic [IW-1:0]      gray_reg;
    logic [DW-1:0]      emit_reg;
    logic [IW:0]        clr_reg;
    lpcs_out_t          out_reg;

    logic [IW-1:0]      top_v;
    logic [IW-1:0]      par_v;
    logic [NODES-1:0]   avail;
    logic               has_w;
    logic [IW-1:0]      w_idx;
    logic [5:0]         reach;
    logic [DW-1:0]      nemit;
    logic [IW:0]        from_i;
    logic [IW:0]        to_i;

    assign top_v = stack_mem[depth_reg[IW-1:0] - IW'(1)];
    assign par_v = stack_mem[depth_reg[IW-1:0] - IW'(2)];
    assign avail = adj_mem[top_v] & cursor_mem[depth_reg[IW-1:0] - IW'(1)];

    always_comb begin
        has_w = |avail;
        w_idx = '0;
        for (int i = NODES - 1; i >= 0; i--) begin
            if (avail[i]) begin
                w_idx = IW'(i);
            end
        end
    end

    assign reach = (node_count > 6'(NODES)) ? 6'(NODES) : node_count;
    assign nemit = (blen_reg > 6'(NODES)) ? DW'(NODES) : DW'(blen_reg);
    assign from_i = (IW+1)'(in_beat.from_node - 6'd1);
    assign to_i   = (IW+1)'(in_beat.to_node - 6'd1);

    assign status.root_done   = ({1'b0, root_reg} >= (IW+2)'(reach));
    assign status.root_white  = (mark_reg[root_reg[IW-1:0]] == MARK_WHITE);
    assign status.stack_empty = (depth_reg == '0);
    assign status.cycle_hit   = has_w && (mark_reg[w_idx] == MARK_GRAY);
    assign status.find_done   = (stack_mem[pos_reg[IW-1:0]] == gray_reg);
    assign status.copy_done   = (pos_reg == depth_reg);
    assign status.path_done   = (bcnt_reg == DW'(blen_reg)) || (bcnt_reg == DW'(NODES));
    assign status.emit_empty  = (nemit == '0);
    assign status.emit_final  = (emit_reg == nemit);
    assign status.clear_done  = (clr_reg == (IW+1)'(NODES));
    assign out_beat = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NODES; i++) begin
                adj_mem[i]  <= '0;
                mark_reg[i] <= MARK_WHITE;
            end
            depth_reg <= '0;
            blen_reg  <= '0;
            cyc_reg   <= 1'b0;
            root_reg  <= '0;
            clr_reg   <= '0;
            emit_reg  <= '0;
        end else begin
            if (cmd.add_edge && in_beat.from_node >= 6'd1 && in_beat.to_node >= 6'd1
                && in_beat.from_node <= 6'(NODES) && in_beat.to_node <= 6'(NODES)) begin
                adj_mem[from_i[IW-1:0]][to_i[IW-1:0]] <= 1'b1;
            end
            if (cmd.init) begin
                for (int i = 0; i < NODES; i++) begin
                    mark_reg[i] <= MARK_WHITE;
                    slen_reg[i] <= '0;
                    snext_reg[i] <= '0;
                end
                root_reg  <= '0;
                blen_reg  <= '0;
                cyc_reg   <= 1'b0;
                depth_reg <= '0;
                first_reg <= '0;
            end
            if (cmd.root_push) begin
                stack_mem[0]  <= root_reg[IW-1:0];
                cursor_mem[0] <= '1;
                depth_reg     <= DW'(1);
                mark_reg[root_reg[IW-1:0]]  <= MARK_GRAY;
                slen_reg[root_reg[IW-1:0]]  <= 6'd1;
                snext_reg[root_reg[IW-1:0]] <= '0;
            end
            if (cmd.root_next) begin
                if (slen_reg[root_reg[IW-1:0]] > blen_reg) begin
                    blen_reg  <= slen_reg[root_reg[IW-1:0]];
                    first_reg <= root_reg[IW-1:0];
                end
                root_reg <= root_reg + 1'b1;
            end
            if (cmd.scan_step) begin
                if (has_w) begin
                    cursor_mem[depth_reg[IW-1:0] - IW'(1)] <=
                        cursor_mem[depth_reg[IW-1:0] - IW'(1)] & ~(NODES'(1) << w_idx)
                        & ~((NODES'(1) << w_idx) - NODES'(1));
                    if (mark_reg[w_idx] == MARK_GRAY) begin
                        gray_reg <= w_idx;
                        pos_reg  <= '0;
                        cyc_reg  <= 1'b1;
                        blen_reg <= '0;
                        bcnt_reg <= '0;
                    end else if (mark_reg[w_idx] == MARK_WHITE) begin
                        stack_mem[depth_reg[IW-1:0]]  <= w_idx;
                        cursor_mem[depth_reg[IW-1:0]] <= '1;
                        depth_reg <= depth_reg + 1'b1;
                        mark_reg[w_idx]  <= MARK_GRAY;
                        slen_reg[w_idx]  <= 6'd1;
                        snext_reg[w_idx] <= '0;
                    end else if (slen_reg[w_idx] + 6'd1 > slen_reg[top_v]) begin
                        slen_reg[top_v]  <= slen_reg[w_idx] + 6'd1;
                        snext_reg[top_v] <= w_idx;
                    end
                end else begin
                    mark_reg[top_v] <= MARK_BLACK;
                    depth_reg <= depth_reg - 1'b1;
                    if (depth_reg > DW'(1) && slen_reg[top_v] + 6'd1 > slen_reg[par_v]) begin
                        slen_reg[par_v]  <= slen_reg[top_v] + 6'd1;
                        snext_reg[par_v] <= top_v;
                    end
                end
            end
            if (cmd.find_step) begin
                pos_reg <= pos_reg + 1'b1;
            end
            if (cmd.copy_step) begin
                best_mem[bcnt_reg[IW-1:0]] <= stack_mem[pos_reg[IW-1:0]];
                bcnt_reg <= bcnt_reg + 1'b1;
                blen_reg <= blen_reg + 6'd1;
                pos_reg  <= pos_reg + 1'b1;
            end
            if (cmd.init) begin
                bcnt_reg <= '0;
            end
            if (cmd.path_step) begin
                if (bcnt_reg == '0) begin
                    best_mem[0] <= first_reg;
                    pv_reg      <= snext_reg[first_reg];
                    bcnt_reg    <= DW'(1);
                end else begin
                    best_mem[bcnt_reg[IW-1:0]] <= pv_reg;
                    pv_reg   <= snext_reg[pv_reg];
                    bcnt_reg <= bcnt_reg + 1'b1;
                end
            end
            if (cmd.emit_load || cmd.emit_next) begin
                out_reg.found_cycle <= cyc_reg;
                out_reg.run_length  <= blen_reg;
                out_reg.node_id     <= 6'(best_mem[emit_reg[IW-1:0]]) + 6'd1;
                out_reg.last        <= (emit_reg + 1'b1 == nemit);
                emit_reg <= emit_reg + 1'b1;
            end
            if (cmd.clear_start) begin
                clr_reg  <= '0;
                emit_reg <= '0;
            end
            if (cmd.clear_step) begin
                adj_mem[clr_reg[IW-1:0]] <= '0;
                clr_reg <= clr_reg + 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

@@ src/lpcs_control.sv @@
// Controller state machine that sequences the search and the result beats.
`default_nettype none
module lpcs_control
    import lpcs_pkg::*;
(
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire logic          s_opcode,
    output logic               m_valid,
    input  wire logic          m_ready,
    input  wire lpcs_status_t  status,
    output lpcs_cmd_t          cmd
);

    lpcs_state_t state_reg, state_next;
    logic        mv_reg, mv_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            mv_reg    <= mv_next;
        end
    end

    assign m_valid = mv_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_opcode == OP_START) state_next = ST_INIT;
            end
            ST_INIT: state_next = ST_ROOT;
            ST_ROOT: begin
                if (status.root_done) state_next = ST_PATH;
                else if (status.root_white) state_next = ST_SCAN;
            end
            ST_SCAN: begin
                if (status.stack_empty) state_next = ST_ROOT;
                else if (status.cycle_hit) state_next = ST_FIND;
            end
            ST_FIND: if (status.find_done) state_next = ST_COPY;
            ST_COPY: if (status.copy_done) state_next = ST_EMIT;
            ST_PATH: if (status.path_done) state_next = ST_EMIT;
            ST_EMIT: begin
                if (status.emit_empty) state_next = ST_CLEAR;
                else if ((!mv_reg || m_ready) && status.emit_final) state_next = ST_CLEAR;
            end
            ST_CLEAR: if (status.clear_done && (!mv_reg || m_ready)) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        mv_next = mv_reg && !m_ready;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready      = 1'b1;
                cmd.add_edge = s_valid && s_opcode == OP_EDGE;
                cmd.init     = s_valid && s_opcode == OP_START;
            end
            ST_INIT: ;
            ST_ROOT: begin
                cmd.root_push = !status.root_done && status.root_white;
                cmd.root_next = !status.root_done && !status.root_white;
                cmd.clear_start = status.root_done;
            end
            ST_SCAN: begin
                cmd.scan_step = !status.stack_empty;
                cmd.root_next = status.stack_empty;
            end
            ST_FIND: cmd.find_step = !status.find_done;
            ST_COPY: begin
                cmd.copy_step   = !status.copy_done;
                cmd.clear_start = status.copy_done;
            end
            ST_PATH: cmd.path_step = !status.path_done;
            ST_EMIT: begin
                if (!status.emit_empty && (!mv_reg || m_ready) && !status.emit_final) begin
                    cmd.emit_next = 1'b1;
                    mv_next = 1'b1;
                end
            end
            ST_CLEAR: cmd.clear_step = !status.clear_done;
            default: ;
        endcase
    end

endmodule
`default_nettype wire

@@ src/longest_path_or_cycle_search.sv @@
// Top level of the longest path or cycle search block.
//   channel   direction  beat
//   s_        in         one edge or a start command
//   m_        out        one node of the reported run
//   cfg_      in         node_count register
// An edge beat is taken while the block is idle; s_ready stays low during a search.
// A search initialises, then visits each root node, follows each edge and leaves each node,
// then finds and copies the stack entries of a cycle or walks the path nodes into the result buffer.
// Result beats leave one per cycle while m_ready is high, then the adjacency memory is cleared.
// Reset is synchronous and active low; m_ready low stalls the run in place.
`default_nettype none
module longest_path_or_cycle_search
    import lpcs_pkg::*;
#(
    parameter int NODES = 32
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire lpcs_in_t   s_data,
    output logic            m_valid,
    input  wire logic       m_ready,
    output lpcs_out_t       m_data,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [5:0] cfg_data
);

    logic [5:0]   node_count_reg;
    lpcs_cmd_t    cmd;
    lpcs_status_t status;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_count_reg <= 6'd32;
        end else if (cfg_valid) begin
            node_count_reg <= cfg_data;
        end
    end

    lpcs_control u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready, .s_opcode(s_data.opcode),
        .m_valid, .m_ready, .status, .cmd
    );

    lpcs_datapath #(.NODES(NODES)) u_dp (
        .aclk, .aresetn, .node_count(node_count_reg), .in_beat(s_data),
        .cmd, .status, .out_beat(m_data)
    );

endmodule
`default_nettype wire

@@ src/lpcs_checker.sv @@
// Port checker for the search block, bound to the top level.
`default_nettype none
module lpcs_checker
    import lpcs_pkg::*;
(
    input wire logic      aclk,
    input wire logic      aresetn,
    input wire logic      s_valid,
    input wire logic      s_ready,
    input wire logic      m_valid,
    input wire logic      m_ready,
    input wire lpcs_out_t m_data
);

    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid)
        else $error("waiting input beat dropped");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result beat changed");

    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("input taken during result run");

    a_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.run_length != 6'd0)
        else $error("result beat with empty run");

endmodule

bind longest_path_or_cycle_search lpcs_checker u_chk (
    .aclk, .aresetn, .s_valid, .s_ready, .m_valid, .m_ready, .m_data
);
`default_nettype wire
